/* rtl/wsm_pkg.sv */
// ----------------------------------------------------------------------------
// wsm_pkg: shared definitions for the 3x3 weighted smoothing filter
// Widths, register indexes, kernel weights and the reciprocal used for the
// divide by 17, plus the types passed between the top level and the lanes.
// ----------------------------------------------------------------------------
package wsm_pkg;

    // Image geometry and line store size.
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = 12;

    // Configuration register file.
    localparam int FW_W      = 11;
    localparam int FH_W      = 12;
    localparam int CFG_DW    = 12;
    localparam int CFG_AW    = 1;
    localparam logic [CFG_AW-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_AW-1:0] REG_FRAME_HEIGHT = 1'd1;
    localparam logic [FW_W-1:0]   FRAME_WIDTH_RST  = 11'd410;
    localparam logic [FH_W-1:0]   FRAME_HEIGHT_RST = 12'd716;
    localparam int MIN_DIM   = 3;

    // Pixel layout: blue in the low byte, then green, then red.
    localparam int CH_W      = 8;
    localparam int NUM_CH    = 3;
    localparam int PIX_W     = CH_W * NUM_CH;

    // Kernel: nine taps, weights 1 2 1 / 2 5 2 / 1 2 1 (sum 17).
    localparam int TAPS      = 9;
    localparam int WGT_W     = 3;
    localparam logic [TAPS-1:0][WGT_W-1:0] KERNEL = {
        3'd1, 3'd2, 3'd1,
        3'd2, 3'd5, 3'd2,
        3'd1, 3'd2, 3'd1
    };

    // Weighted sum is at most 17 * 255 = 4335, which fits in 13 bits.
    localparam int SUM_W       = 13;
    // floor(s / 17) == (s * 7711) >> 17 for every s below 8192.
    localparam int RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP_17 = 13'd7711;
    localparam int RECIP_SHIFT = 17;
    localparam int PROD_W      = SUM_W + RECIP_W;

    typedef logic [TAPS-1:0][CH_W-1:0] taps_t;

    // Load strobes for the two register stages of a lane.
    typedef struct packed {
        logic load_sum;
        logic load_quot;
    } lane_ctrl_t;

endpackage

/* rtl/wsm_ram.sv */
// ----------------------------------------------------------------------------
// wsm_ram: generic simple dual-port RAM
// One write port and one read port with a registered read that holds its
// data while no read is issued.
// ----------------------------------------------------------------------------
module wsm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/wsm_lane.sv */
// ----------------------------------------------------------------------------
// wsm_lane: one color channel of the smoothing filter
// Forms the weighted sum of the nine window taps, then divides it by 17
// through a reciprocal multiply. Two register stages.
// ----------------------------------------------------------------------------
module wsm_lane (
    input  logic                      aclk,
    input  wsm_pkg::lane_ctrl_t       ctrl,
    input  wsm_pkg::taps_t            taps,
    output logic [wsm_pkg::CH_W-1:0]  chan_out
);
    import wsm_pkg::*;

    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [PROD_W-1:0] prod;
    logic [CH_W-1:0]   quot_reg;
    logic [CH_W-1:0]   quot_next;

    // Weighted sum of the nine taps; the weights are small constants.
    always_comb begin
        sum_next = '0;
        for (int t = 0; t < TAPS; t++) begin
            sum_next = sum_next + SUM_W'(taps[t]) * SUM_W'(KERNEL[t]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_sum) begin
            sum_reg <= sum_next;
        end
    end

    // Divide by 17 with truncation: multiply by the reciprocal and shift.
    assign prod      = PROD_W'(sum_reg) * PROD_W'(RECIP_17);
    assign quot_next = prod[RECIP_SHIFT +: CH_W];

    always_ff @(posedge aclk) begin
        if (ctrl.load_quot) begin
            quot_reg <= quot_next;
        end
    end

    assign chan_out = quot_reg;

endmodule

/* rtl/weighted_smoothing_3x3_top.sv */
// ----------------------------------------------------------------------------
// weighted_smoothing_3x3_top: streaming 3x3 weighted smoothing filter
// Filters each channel of a raster pixel stream with the kernel
// 1 2 1 / 2 5 2 / 1 2 1 divided by 17, and emits the interior pixels only.
//
//   Channel  | Ports          | Contents
//   ---------+----------------+------------------------------------------------
//   input    | s_axis_*       | tdata: blue, green, red; tuser: frame_start
//   output   | m_axis_*       | tdata: blue, green, red; tlast: line_end;
//            |                | tuser: frame_end
//   config   | cfg_*          | index 0 frame_width, index 1 frame_height
//
// One pixel is accepted per clock while the output is not stalled. A result
// passes three register stages on its way to the output: the line store
// read, the tap sum and the reciprocal multiply.
// A stalled output holds the whole pipeline, and s_axis_tready falls with it.
// Reset is synchronous; the line stores need no clearing after reset.
// ----------------------------------------------------------------------------
module weighted_smoothing_3x3_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Input pixel stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [23:0]                  s_axis_tdata,  // in_blue, in_green, in_red
    input  logic                         s_axis_tuser,  // frame_start
    // Filtered pixel stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [23:0]                  m_axis_tdata,  // out_blue, out_green, out_red
    output logic                         m_axis_tlast,  // line_end
    output logic                         m_axis_tuser,  // frame_end
    // Configuration write port
    input  logic                         cfg_we,
    input  logic [wsm_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [wsm_pkg::CFG_DW-1:0]   cfg_wdata
);
    import wsm_pkg::*;

    // Configuration registers.
    logic [FW_W-1:0]  frame_width_reg;
    logic [FH_W-1:0]  frame_height_reg;

    // Position counters.
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_eff, wlast;
    logic [ROW_W-1:0] row_eff, hlast;
    logic             line_end, frame_end, emit;

    // Pipeline control.
    logic             advance, accept;

    // Stage 1: line store data arrives.
    logic             v1_reg;
    logic             emit1_reg, le1_reg, fe1_reg;
    logic [COL_W-1:0] col1_reg;
    logic [PIX_W-1:0] cur1_reg;
    logic             byp1_reg;
    logic [PIX_W-1:0] byp_up_reg, byp_mid_reg;
    logic [PIX_W-1:0] up_rdata, mid_rdata, up_eff, mid_eff;

    // Window of the two previous columns of three rows.
    logic [PIX_W-1:0] win0_reg, win1_reg, win2_reg, win3_reg, win4_reg, win5_reg;

    // Stage 2 and output stage flags.
    logic             v2_reg, le2_reg, fe2_reg;
    logic             mvalid_reg, mlast_reg, muser_reg;

    lane_ctrl_t       lane_ctrl;
    taps_t            lane_taps [NUM_CH];
    logic [CH_W-1:0]  lane_out  [NUM_CH];

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[FH_W-1:0];
                default: ;
            endcase
        end
    end

    // Last column and last row indexes after clamping the geometry.
    always_comb begin
        if (frame_width_reg < FW_W'(MIN_DIM)) begin
            wlast = COL_W'(MIN_DIM - 1);
        end else if (frame_width_reg > FW_W'(MAX_WIDTH)) begin
            wlast = COL_W'(MAX_WIDTH - 1);
        end else begin
            wlast = COL_W'(frame_width_reg - FW_W'(1));
        end
        if (frame_height_reg < FH_W'(MIN_DIM)) begin
            hlast = ROW_W'(MIN_DIM - 1);
        end else begin
            hlast = ROW_W'(frame_height_reg - FH_W'(1));
        end
    end

    // The whole pipeline moves whenever the output register can take data.
    assign advance       = !mvalid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && advance;
    assign s_axis_tready = advance;

    // Position of the incoming pixel; a frame start forces the origin.
    assign col_eff   = s_axis_tuser ? '0 : col_reg;
    assign row_eff   = s_axis_tuser ? '0 : row_reg;
    assign line_end  = (col_eff >= wlast);
    assign frame_end = line_end && (row_eff >= hlast);
    assign emit      = (row_eff >= ROW_W'(2)) && (col_eff >= COL_W'(2));

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (line_end) begin
                col_next = '0;
                row_next = (row_eff >= hlast) ? '0 : row_eff + ROW_W'(1);
            end else begin
                col_next = col_eff + COL_W'(1);
                row_next = row_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Line stores: rows two above and one above the incoming pixel.
    assign up_eff  = byp1_reg ? byp_up_reg  : up_rdata;
    assign mid_eff = byp1_reg ? byp_mid_reg : mid_rdata;

    wsm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper_store (
        .aclk  (aclk),
        .we    (v1_reg && advance),
        .waddr (col1_reg),
        .wdata (mid_eff),
        .re    (accept),
        .raddr (col_eff),
        .rdata (up_rdata)
    );

    wsm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lower_store (
        .aclk  (aclk),
        .we    (v1_reg && advance),
        .waddr (col1_reg),
        .wdata (cur1_reg),
        .re    (accept),
        .raddr (col_eff),
        .rdata (mid_rdata)
    );

    // Stage 1 control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= accept;
        end
    end

    // Stage 1 payload; a read of the column being written this cycle takes
    // the write data directly instead of the stale store contents.
    always_ff @(posedge aclk) begin
        if (accept) begin
            emit1_reg   <= emit;
            le1_reg     <= line_end;
            fe1_reg     <= frame_end;
            col1_reg    <= col_eff;
            cur1_reg    <= s_axis_tdata;
            byp1_reg    <= v1_reg && (col1_reg == col_eff);
            byp_up_reg  <= mid_eff;
            byp_mid_reg <= cur1_reg;
        end
    end

    // Window shift as each pixel leaves stage 1.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win0_reg <= '0;
            win1_reg <= '0;
            win2_reg <= '0;
            win3_reg <= '0;
            win4_reg <= '0;
            win5_reg <= '0;
        end else if (v1_reg && advance) begin
            win3_reg <= win0_reg;
            win4_reg <= win1_reg;
            win5_reg <= win2_reg;
            win0_reg <= up_eff;
            win1_reg <= mid_eff;
            win2_reg <= cur1_reg;
        end
    end

    // Per-channel lanes: sum in stage 2, quotient in the output stage.
    assign lane_ctrl.load_sum  = advance;
    assign lane_ctrl.load_quot = advance;

    for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
        assign lane_taps[c][0] = win3_reg[c*CH_W +: CH_W];
        assign lane_taps[c][1] = win0_reg[c*CH_W +: CH_W];
        assign lane_taps[c][2] = up_eff  [c*CH_W +: CH_W];
        assign lane_taps[c][3] = win4_reg[c*CH_W +: CH_W];
        assign lane_taps[c][4] = win1_reg[c*CH_W +: CH_W];
        assign lane_taps[c][5] = mid_eff [c*CH_W +: CH_W];
        assign lane_taps[c][6] = win5_reg[c*CH_W +: CH_W];
        assign lane_taps[c][7] = win2_reg[c*CH_W +: CH_W];
        assign lane_taps[c][8] = cur1_reg[c*CH_W +: CH_W];

        wsm_lane u_lane (
            .aclk     (aclk),
            .ctrl     (lane_ctrl),
            .taps     (lane_taps[c]),
            .chan_out (lane_out[c])
        );
    end

    // Stage 2 and output stage control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg     <= 1'b0;
            mvalid_reg <= 1'b0;
        end else if (advance) begin
            v2_reg     <= v1_reg && emit1_reg;
            mvalid_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            le2_reg   <= le1_reg;
            fe2_reg   <= fe1_reg;
            mlast_reg <= le2_reg;
            muser_reg <= fe2_reg;
        end
    end

    // Merge the lanes into the output transfer.
    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = {lane_out[2], lane_out[1], lane_out[0]};
    assign m_axis_tlast  = mlast_reg;
    assign m_axis_tuser  = muser_reg;

endmodule
